### sv/ppcc_pkg.sv
package ppcc_pkg;

  localparam int unsigned FieldWidth = 16;
  localparam logic [FieldWidth-1:0] PipeDepthRst = 16'd16;
  localparam logic [FieldWidth-1:0] SendableMax = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_CREDIT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    VIS_IMMEDIATE = 2'd0,
    VIS_FIFO      = 2'd1,
    VIS_DEFERRED  = 2'd2
  } vis_e;

  typedef enum logic [1:0] {
    CFG_VISIBILITY = 2'd0,
    CFG_DEPTH      = 2'd1,
    CFG_AUTO_FLUSH = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] VisibilityRst = VIS_FIFO;

  typedef struct packed {
    logic [1:0]            op;
    logic [FieldWidth-1:0] elem_count_req;
    logic                  end_of_message;
    logic [FieldWidth-1:0] credit_amount;
    logic                  consumer_underflow;
  } item_t;

  typedef struct packed {
    logic [FieldWidth-1:0] accepted;
    logic                  send_message;
    logic                  message_fail;
    logic                  message_flush;
    logic                  eom_marked;
    logic                  retry_notify;
    logic                  flush_complete;
    logic                  wake_notify;
    logic [FieldWidth-1:0] credits_available;
  } res_t;

  typedef struct packed {
    logic overflow;
    logic flushing;
    logic active;
    logic pending_receive;
  } flags_t;

  localparam flags_t FlagsRst = '{overflow: 1'b0, flushing: 1'b0, active: 1'b1,
                                  pending_receive: 1'b0};

endpackage

### sv/ppcc_in_stage.sv
module ppcc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  ppcc_pkg::item_t item_i,
  input  logic            advance_i,
  output logic            in_stall_o,
  output logic            valid_o,
  output ppcc_pkg::item_t item_o
);
  import ppcc_pkg::*;

  logic  valid_q, valid_d;
  logic  load;
  item_t item_q;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### sv/ppcc_step.sv
module ppcc_step #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic [1:0]             visibility_i,
  input  logic                   auto_flush_i,
  input  logic [COUNT_WIDTH-1:0] depth_i,
  input  logic [COUNT_WIDTH-1:0] credits_i,
  input  logic [COUNT_WIDTH-1:0] batched_i,
  input  ppcc_pkg::flags_t       flags_i,
  input  ppcc_pkg::item_t        item_i,
  output logic [COUNT_WIDTH-1:0] credits_o,
  output logic [COUNT_WIDTH-1:0] batched_o,
  output ppcc_pkg::flags_t       flags_o,
  output ppcc_pkg::res_t         res_o
);
  import ppcc_pkg::*;

  localparam int unsigned WideWidth = (COUNT_WIDTH > FieldWidth) ? COUNT_WIDTH : FieldWidth;
  localparam int unsigned SumWidth  = WideWidth + 1;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic                   deferred;
  logic                   fifo;
  logic [WideWidth-1:0]   credits_w;
  logic [WideWidth-1:0]   req_w;
  logic [FieldWidth-1:0]  min_acc;
  logic [FieldWidth-1:0]  acc;
  logic                   all_acc;
  logic                   data_push;
  logic [SumWidth-1:0]    sum;
  logic [SumWidth-1:0]    depth_s;
  logic [SumWidth-1:0]    ret_sum;
  logic [COUNT_WIDTH-1:0] ret_credits;
  logic [COUNT_WIDTH-1:0] thr;
  logic                   empty;
  logic                   end_ovf;
  logic                   ret_send;
  logic [WideWidth-1:0]   cr_out_w;

  assign deferred  = (visibility_i == VIS_DEFERRED);
  assign fifo      = (visibility_i == VIS_FIFO);
  assign credits_w = WideWidth'(credits_i);
  assign req_w     = WideWidth'(item_i.elem_count_req);
  assign min_acc   = (credits_w < req_w) ? credits_w[FieldWidth-1:0] : item_i.elem_count_req;
  assign acc       = (deferred && !flags_i.active) ? '0 : min_acc;
  assign all_acc   = (acc == item_i.elem_count_req);
  assign depth_s   = SumWidth'(depth_i);
  assign sum       = SumWidth'(batched_i) + SumWidth'(acc);
  assign ret_sum   = SumWidth'(credits_i) + SumWidth'(item_i.credit_amount);
  assign ret_credits = (ret_sum > depth_s) ? depth_i : ret_sum[COUNT_WIDTH-1:0];
  assign thr       = fifo ? COUNT_WIDTH'(1) : depth_i;
  assign empty     = (ret_credits == depth_i) && (item_i.credit_amount != '0);

  always_comb begin
    credits_o = credits_i;
    batched_o = batched_i;
    flags_o   = flags_i;
    res_o     = '0;
    data_push = 1'b0;
    end_ovf   = 1'b0;
    ret_send  = 1'b0;
    case (op_e'(item_i.op))
      OP_SEND: begin
        if (item_i.elem_count_req != '0 && !flags_i.flushing) begin
          if (deferred) begin
            data_push = (sum == depth_s) && (!all_acc || flags_i.pending_receive);
            res_o.message_fail = !all_acc && !flags_i.overflow;
          end else begin
            data_push = (acc != '0);
          end
          res_o.accepted      = acc;
          res_o.eom_marked    = item_i.end_of_message && all_acc && (acc != '0);
          res_o.message_flush = item_i.end_of_message && all_acc && auto_flush_i;
          res_o.send_message  = data_push || res_o.message_fail || res_o.message_flush;
          if (res_o.send_message) begin
            batched_o = '0;
          end else if (sum > SumWidth'(CountMax)) begin
            batched_o = CountMax;
          end else begin
            batched_o = sum[COUNT_WIDTH-1:0];
          end
          credits_o      = credits_i - COUNT_WIDTH'(acc);
          flags_o.overflow = (flags_i.overflow && !res_o.message_flush) || !all_acc;
          if (data_push) begin
            flags_o.active = 1'b0;
          end
          flags_o.flushing   = res_o.message_flush;
          res_o.retry_notify = !all_acc;
        end
      end
      OP_FLUSH: begin
        if (credits_i == depth_i) begin
          res_o.flush_complete = 1'b1;
        end else if (!flags_i.flushing) begin
          res_o.send_message  = 1'b1;
          res_o.message_flush = 1'b1;
          batched_o        = '0;
          flags_o.overflow = 1'b0;
          flags_o.flushing = 1'b1;
        end
        res_o.retry_notify = !res_o.flush_complete;
      end
      OP_CREDIT: begin
        if (deferred) begin
          ret_send = (batched_i == depth_i) && item_i.consumer_underflow;
          end_ovf  = flags_i.overflow && (item_i.credit_amount != '0);
          if (ret_send) begin
            res_o.send_message = 1'b1;
            batched_o = '0;
          end
        end else begin
          end_ovf = flags_i.overflow && (ret_credits >= thr);
        end
        res_o.wake_notify = end_ovf || ((deferred || flags_i.flushing) && empty);
        credits_o = ret_credits;
        if (end_ovf) begin
          flags_o.overflow = 1'b0;
        end
        if (empty) begin
          flags_o.flushing = 1'b0;
        end
        if (item_i.credit_amount != '0) begin
          flags_o.active = 1'b1;
        end
        flags_o.pending_receive = (flags_i.pending_receive || item_i.consumer_underflow)
                                  && !ret_send;
      end
      default: begin
      end
    endcase
    cr_out_w = WideWidth'(credits_o);
    if (flags_o.flushing || (deferred && !flags_o.active)) begin
      res_o.credits_available = '0;
    end else if (cr_out_w > WideWidth'(SendableMax)) begin
      res_o.credits_available = SendableMax;
    end else begin
      res_o.credits_available = cr_out_w[FieldWidth-1:0];
    end
  end

endmodule

### sv/pipe_producer_credit_control.sv
// credit-based pipe producer, one request per transaction, one result per request
// path: input register, then state update, then result register
// throughput: one transaction per cycle unless out_stall_i holds a valid result
// config writes take effect from the next cycle on, cfg_ready_o is always high
// reset: depth 16, fifo visibility, auto flush off, full credits, active, other flags clear
module pipe_producer_credit_control #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] elem_count_req_i,
  input  logic        end_of_message_i,
  input  logic [15:0] credit_amount_i,
  input  logic        consumer_underflow_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] accepted_o,
  output logic        send_message_o,
  output logic        message_fail_o,
  output logic        message_flush_o,
  output logic        eom_marked_o,
  output logic        retry_notify_o,
  output logic        flush_complete_o,
  output logic        wake_notify_o,
  output logic [15:0] credits_available_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ppcc_pkg::*;

  localparam int unsigned WideWidth = (COUNT_WIDTH > FieldWidth) ? COUNT_WIDTH : FieldWidth;
  localparam logic [WideWidth-1:0] CountMaxW = WideWidth'({COUNT_WIDTH{1'b1}});
  localparam logic [COUNT_WIDTH-1:0] CreditsRst =
    (WideWidth'(PipeDepthRst) > CountMaxW) ? COUNT_WIDTH'(CountMaxW)
                                           : COUNT_WIDTH'(PipeDepthRst);

  item_t                  in_item;
  item_t                  s1_item;
  logic                   s1_valid;
  logic                   advance;
  logic                   fire;
  logic                   cfg_we;

  logic [1:0]             visibility_q, visibility_d;
  logic [15:0]            pipe_depth_q, pipe_depth_d;
  logic                   auto_flush_q, auto_flush_d;
  logic [COUNT_WIDTH-1:0] eff_depth;
  logic [COUNT_WIDTH-1:0] new_depth;
  logic [WideWidth-1:0]   data_w;
  logic [WideWidth-1:0]   depth_w;

  logic [COUNT_WIDTH-1:0] credits_q, credits_d, credits_nx;
  logic [COUNT_WIDTH-1:0] batched_q, batched_d, batched_nx;
  flags_t                 flags_q, flags_d, flags_nx;

  res_t                   res;
  res_t                   out_q;
  logic                   out_valid_q, out_valid_d;

  assign in_item = '{op: op_i, elem_count_req: elem_count_req_i,
                     end_of_message: end_of_message_i, credit_amount: credit_amount_i,
                     consumer_underflow: consumer_underflow_i};

  assign advance = !out_valid_q || !out_stall_i;
  assign fire    = s1_valid && advance;

  ppcc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (in_item),
    .advance_i  (advance),
    .in_stall_o (in_stall_o),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  // effective depth is capped at the counter range
  assign depth_w   = WideWidth'(pipe_depth_q);
  assign eff_depth = (depth_w > CountMaxW) ? COUNT_WIDTH'(CountMaxW) : COUNT_WIDTH'(depth_w);
  assign data_w    = WideWidth'(cfg_data_i);
  assign new_depth = (data_w > CountMaxW) ? COUNT_WIDTH'(CountMaxW) : COUNT_WIDTH'(data_w);

  ppcc_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .visibility_i (visibility_q),
    .auto_flush_i (auto_flush_q),
    .depth_i      (eff_depth),
    .credits_i    (credits_q),
    .batched_i    (batched_q),
    .flags_i      (flags_q),
    .item_i       (s1_item),
    .credits_o    (credits_nx),
    .batched_o    (batched_nx),
    .flags_o      (flags_nx),
    .res_o        (res)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    visibility_d = visibility_q;
    pipe_depth_d = pipe_depth_q;
    auto_flush_d = auto_flush_q;
    credits_d    = credits_q;
    batched_d    = batched_q;
    flags_d      = flags_q;
    if (fire) begin
      credits_d = credits_nx;
      batched_d = batched_nx;
      flags_d   = flags_nx;
    end
    if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_VISIBILITY: begin
          visibility_d = cfg_data_i[1:0];
        end
        CFG_DEPTH: begin
          pipe_depth_d = cfg_data_i;
          credits_d    = new_depth;
        end
        CFG_AUTO_FLUSH: begin
          auto_flush_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visibility_q <= VisibilityRst;
      pipe_depth_q <= PipeDepthRst;
      auto_flush_q <= 1'b0;
      credits_q    <= CreditsRst;
      batched_q    <= '0;
      flags_q      <= FlagsRst;
      out_valid_q  <= 1'b0;
    end else begin
      visibility_q <= visibility_d;
      pipe_depth_q <= pipe_depth_d;
      auto_flush_q <= auto_flush_d;
      credits_q    <= credits_d;
      batched_q    <= batched_d;
      flags_q      <= flags_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign accepted_o          = out_q.accepted;
  assign send_message_o      = out_q.send_message;
  assign message_fail_o      = out_q.message_fail;
  assign message_flush_o     = out_q.message_flush;
  assign eom_marked_o        = out_q.eom_marked;
  assign retry_notify_o      = out_q.retry_notify;
  assign flush_complete_o    = out_q.flush_complete;
  assign wake_notify_o       = out_q.wake_notify;
  assign credits_available_o = out_q.credits_available;

  a_credits_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credits_q <= eff_depth)
    else $error("credits above depth");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed transaction lost");

  a_fail_has_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.message_fail) |-> out_q.send_message)
    else $error("fail mark without message");

  a_flush_done_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.flush_complete) |-> !out_q.retry_notify)
    else $error("flush complete with retry");

endmodule

### tb/sv/pipe_producer_credit_control_tb.sv
module pipe_producer_credit_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppcc_pkg::*;

  localparam logic [1:0] VisUnused = 2'd3;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned PrintLimit = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [15:0] elem_count_req_i = '0;
  logic        end_of_message_i = 1'b0;
  logic [15:0] credit_amount_i = '0;
  logic        consumer_underflow_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] accepted_o;
  logic        send_message_o;
  logic        message_fail_o;
  logic        message_flush_o;
  logic        eom_marked_o;
  logic        retry_notify_o;
  logic        flush_complete_o;
  logic        wake_notify_o;
  logic [15:0] credits_available_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  pipe_producer_credit_control dut (.*);

  // producer state as tracked by the testbench
  logic [1:0]  vis_mode = VisibilityRst;
  logic [15:0] depth_cfg = PipeDepthRst;
  logic        autoflush_en = 1'b0;
  logic [15:0] cr_cnt = PipeDepthRst;
  logic [15:0] batch_cnt = '0;
  flags_t      fl = FlagsRst;

  res_t awaited_res[$];
  int   err_cnt = 0;
  int   quiet_cycles = 0;
  int   gap_free_left = 0;
  bit   rx_hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic res_t predict_result(input item_t it);
    res_t r;
    logic dfr, all_in, push, empty, end_ovf;
    logic [15:0] acc;
    logic [16:0] sum, nc, thr;
    r = '0;
    push = 1'b0;
    end_ovf = 1'b0;
    dfr = (vis_mode == VIS_DEFERRED);
    case (it.op)
      OP_SEND: begin
        if (it.elem_count_req != '0 && !fl.flushing) begin
          acc = (cr_cnt < it.elem_count_req) ? cr_cnt : it.elem_count_req;
          if (dfr && !fl.active) acc = '0;
          all_in = (acc == it.elem_count_req);
          sum = {1'b0, batch_cnt} + {1'b0, acc};
          if (dfr) begin
            push = (sum == {1'b0, depth_cfg}) && (!all_in || fl.pending_receive);
            r.message_fail = !all_in && !fl.overflow;
          end else begin
            push = (acc != '0);
          end
          r.accepted = acc;
          r.eom_marked = it.end_of_message && all_in && (acc != '0);
          r.message_flush = it.end_of_message && all_in && autoflush_en;
          r.send_message = push || r.message_fail || r.message_flush;
          batch_cnt = r.send_message ? '0 : (sum[16] ? 16'hFFFF : sum[15:0]);
          cr_cnt = cr_cnt - acc;
          fl.overflow = (fl.overflow && !r.message_flush) || !all_in;
          if (push) fl.active = 1'b0;
          fl.flushing = r.message_flush;
          r.retry_notify = !all_in;
        end
      end
      OP_FLUSH: begin
        if (cr_cnt == depth_cfg) begin
          r.flush_complete = 1'b1;
        end else if (!fl.flushing) begin
          r.send_message = 1'b1;
          r.message_flush = 1'b1;
          batch_cnt = '0;
          fl.overflow = 1'b0;
          fl.flushing = 1'b1;
        end
        r.retry_notify = !r.flush_complete;
      end
      OP_CREDIT: begin
        nc = {1'b0, cr_cnt} + {1'b0, it.credit_amount};
        if (nc > {1'b0, depth_cfg}) nc = {1'b0, depth_cfg};
        empty = (nc == {1'b0, depth_cfg}) && (it.credit_amount != '0);
        if (dfr) begin
          push = (batch_cnt == depth_cfg) && it.consumer_underflow;
          end_ovf = fl.overflow && (it.credit_amount != '0);
          if (push) begin
            r.send_message = 1'b1;
            batch_cnt = '0;
          end
        end else begin
          thr = (vis_mode == VIS_FIFO) ? 17'd1 : {1'b0, depth_cfg};
          end_ovf = fl.overflow && (nc >= thr);
        end
        r.wake_notify = end_ovf || ((dfr || fl.flushing) && empty);
        cr_cnt = nc[15:0];
        if (end_ovf) fl.overflow = 1'b0;
        if (empty) fl.flushing = 1'b0;
        if (it.credit_amount != '0) fl.active = 1'b1;
        fl.pending_receive = (fl.pending_receive || it.consumer_underflow) && !push;
      end
      default: ;
    endcase
    r.credits_available = (fl.flushing || (dfr && !fl.active)) ? '0 : cr_cnt;
    return r;
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= PrintLimit) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] got,
                           input logic [15:0] exp);
    if (got !== exp) note_error($sformatf("%s got %0h exp %0h", name, got, exp));
  endtask

  task automatic cmp_flag(input string name, input logic got, input logic exp);
    if (got !== exp) note_error($sformatf("%s got %0b exp %0b", name, got, exp));
  endtask

  // input and register transactions feed the predictor
  always @(posedge clk_i) begin : req_mon
    item_t it;
    if (rst_ni && in_valid_i && in_stall_o === 1'b0) begin
      it = {op_i, elem_count_req_i, end_of_message_i, credit_amount_i, consumer_underflow_i};
      awaited_res.push_back(predict_result(it));
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o === 1'b1) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_VISIBILITY: vis_mode = cfg_data_i[1:0];
        CFG_DEPTH: begin
          depth_cfg = cfg_data_i;
          cr_cnt = cfg_data_i;
        end
        CFG_AUTO_FLUSH: autoflush_en = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : res_chk
    res_t got;
    res_t exp;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = {accepted_o, send_message_o, message_fail_o, message_flush_o, eom_marked_o,
             retry_notify_o, flush_complete_o, wake_notify_o, credits_available_o};
      if (awaited_res.size() == 0) begin
        note_error("result with nothing expected");
      end else begin
        exp = awaited_res.pop_front();
        cmp_field("accepted", got.accepted, exp.accepted);
        cmp_flag("send_message", got.send_message, exp.send_message);
        cmp_flag("message_fail", got.message_fail, exp.message_fail);
        cmp_flag("message_flush", got.message_flush, exp.message_flush);
        cmp_flag("eom_marked", got.eom_marked, exp.eom_marked);
        cmp_flag("retry_notify", got.retry_notify, exp.retry_notify);
        cmp_flag("flush_complete", got.flush_complete, exp.flush_complete);
        cmp_flag("wake_notify", got.wake_notify, exp.wake_notify);
        cmp_field("credits_available", got.credits_available, exp.credits_available);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles > QuietLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side stall pattern, with a long hold on request
  initial begin : rx_side
    int run;
    int hold;
    int k;
    run = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (run > 0) begin
        run--;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 50) begin
          out_stall_i <= 1'b0;
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
        end else begin
          out_stall_i <= 1'b1;
          if (k < 85) run = $urandom_range(0, 1);
          else if (k < 97) run = $urandom_range(2, 7);
          else run = $urandom_range(19, 49);
        end
      end
    end
  end

  task automatic issue(input item_t it);
    int k;
    int gap;
    in_valid_i <= 1'b1;
    op_i <= it.op;
    elem_count_req_i <= it.elem_count_req;
    end_of_message_i <= it.end_of_message;
    credit_amount_i <= it.credit_amount;
    consumer_underflow_i <= it.consumer_underflow;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    gap = 0;
    if (gap_free_left > 0) begin
      gap_free_left--;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 3) gap_free_left = $urandom_range(20, 50);
      else if (k < 50) gap = 0;
      else if (k < 82) gap = $urandom_range(1, 2);
      else if (k < 97) gap = $urandom_range(3, 8);
      else gap = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_res.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  task automatic configure(input logic [1:0] vis, input logic [15:0] depth, input logic af);
    drain();
    write_reg(CFG_VISIBILITY, {14'd0, vis});
    write_reg(CFG_DEPTH, depth);
    write_reg(CFG_AUTO_FLUSH, {15'd0, af});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic item_t mk(input logic [1:0] op, input logic [15:0] req, input logic eom,
                               input logic [15:0] amt, input logic uf);
    item_t it;
    it.op = op;
    it.elem_count_req = req;
    it.end_of_message = eom;
    it.credit_amount = amt;
    it.consumer_underflow = uf;
    return it;
  endfunction

  function automatic logic [15:0] rand_count(input int unsigned lim);
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return 16'hFFFF;
    if (k < 4) return 16'($urandom);
    return 16'($urandom_range(1, lim));
  endfunction

  function automatic item_t rand_req();
    item_t it;
    int k;
    int unsigned lim;
    lim = (depth_cfg > 40) ? 40 : depth_cfg + 2;
    k = $urandom_range(0, 99);
    if (k < 50) it.op = OP_SEND;
    else if (k < 88) it.op = OP_CREDIT;
    else if (k < 97) it.op = OP_FLUSH;
    else it.op = OpUnused;
    it.elem_count_req = rand_count(lim);
    it.end_of_message = ($urandom_range(0, 9) < 4);
    it.credit_amount = rand_count(lim);
    it.consumer_underflow = ($urandom_range(0, 9) < 3);
    return it;
  endfunction

  task automatic test_fifo_basics();
    issue(mk(OP_FLUSH, 16'd0, 1'b0, 16'd0, 1'b0));
    issue(mk(OP_SEND, 16'd0, 1'b1, 16'd0, 1'b0));
    issue(mk(OP_SEND, 16'd16, 1'b1, 16'd0, 1'b0));
    issue(mk(OP_SEND, 16'hFFFF, 1'b0, 16'hFFFF, 1'b1));
    issue(mk(OP_CREDIT, 16'hFFFF, 1'b1, 16'd3, 1'b0));
    issue(mk(OpUnused, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1));
    issue(mk(OP_FLUSH, 16'd0, 1'b0, 16'd0, 1'b0));
    issue(mk(OP_SEND, 16'd5, 1'b1, 16'd0, 1'b0));
    issue(mk(OP_CREDIT, 16'd0, 1'b0, 16'hFFFF, 1'b1));
  endtask

  task automatic test_auto_flush_wide();
    configure(VIS_IMMEDIATE, 16'hFFFF, 1'b1);
    issue(mk(OP_SEND, 16'hFFFF, 1'b1, 16'd0, 1'b0));
    issue(mk(OP_CREDIT, 16'd0, 1'b0, 16'hFFFF, 1'b1));
    issue(mk(OP_SEND, 16'd1, 1'b1, 16'd0, 1'b0));
    issue(mk(OP_CREDIT, 16'd0, 1'b0, 16'd1, 1'b0));
    configure(VisUnused, 16'd1, 1'b0);
    issue(mk(OP_SEND, 16'd2, 1'b0, 16'd0, 1'b0));
    issue(mk(OP_CREDIT, 16'd0, 1'b0, 16'd1, 1'b0));
  endtask

  task automatic test_deferred_batching();
    configure(VIS_DEFERRED, 16'd4, 1'b0);
    issue(mk(OP_SEND, 16'd2, 1'b0, 16'd0, 1'b0));
    issue(mk(OP_SEND, 16'd2, 1'b1, 16'd0, 1'b0));
    issue(mk(OP_CREDIT, 16'd0, 1'b0, 16'd0, 1'b1));
    issue(mk(OP_SEND, 16'd1, 1'b0, 16'd0, 1'b0));
    issue(mk(OP_CREDIT, 16'd0, 1'b0, 16'd4, 1'b0));
  endtask

  task automatic test_zero_depth();
    configure(VIS_DEFERRED, 16'd0, 1'b1);
    issue(mk(OP_FLUSH, 16'd0, 1'b0, 16'd0, 1'b0));
    issue(mk(OP_SEND, 16'd1, 1'b1, 16'd0, 1'b0));
    issue(mk(OP_CREDIT, 16'd0, 1'b0, 16'd5, 1'b1));
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: configure(VIS_IMMEDIATE, 16'd8, 1'b0);
        1: configure(VIS_FIFO, 16'd1, 1'b1);
        2: configure(VIS_DEFERRED, 16'd4, 1'b0);
        3: configure(VIS_DEFERRED, 16'd16, 1'b1);
        4: configure(VisUnused, 16'($urandom_range(2, 32)), 1'($urandom_range(0, 1)));
        5: configure(VIS_FIFO, 16'hFFFF, 1'b0);
        6: configure(VIS_DEFERRED, 16'd1, 1'b1);
        7: configure(VIS_IMMEDIATE, 16'($urandom_range(1, 65535)), 1'b1);
        default: configure(2'($urandom_range(0, 2)), 16'($urandom_range(1, 12)),
                           1'($urandom_range(0, 1)));
      endcase
      repeat (200) issue(rand_req());
    end
  endtask

  task automatic test_backpressure();
    configure(VIS_FIFO, 16'd6, 1'b0);
    rx_hold_req = 1'b1;
    gap_free_left = 40;
    repeat (40) issue(rand_req());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fifo_basics();
    test_auto_flush_wide();
    test_deferred_batching();
    test_zero_depth();
    test_random_traffic();
    test_backpressure();
    drain();
    repeat (6) @(posedge clk_i);
    if (awaited_res.size() != 0) note_error("results still expected at end");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/ppcc_pkg.sv
sv/ppcc_in_stage.sv
sv/ppcc_step.sv
sv/pipe_producer_credit_control.sv
tb/sv/pipe_producer_credit_control_tb.sv
